// ===== hw/rtl/clbc_pkg.sv =====
// Shared types and constants for the card number Luhn and brand checker.
package clbc_pkg;

	localparam int unsigned CardWidth = 64;
	localparam int unsigned NumCells = 20;
	localparam int unsigned MaxDigits = 19;
	localparam int unsigned CntWidth = $clog2(CardWidth);
	localparam int unsigned IdxWidth = $clog2(NumCells);

	typedef logic [3:0] digit_t;
	typedef logic [4:0] count_t;
	typedef logic [1:0] brand_t;

	localparam brand_t BRAND_INVALID = 2'd0;
	localparam brand_t BRAND_AMEX = 2'd1;
	localparam brand_t BRAND_VISA = 2'd2;
	localparam brand_t BRAND_MASTER = 2'd3;

	localparam count_t MIN_DIGITS = 5'd13;
	localparam count_t AMEX_DIGITS = 5'd15;
	localparam count_t VISA_SHORT_DIGITS = 5'd13;
	localparam count_t CARD_DIGITS = 5'd16;
	localparam count_t MAX_DIGITS_C = count_t'(MaxDigits);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_CONV,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		count_t digit_count;
		logic   luhn_ok;
		digit_t lead_hi;
		digit_t lead_lo;
	} scan_res_t;

endpackage

// ===== hw/rtl/clbc_cell.sv =====
// One decimal digit cell of the shift-and-add-3 conversion chain.
module clbc_cell (
	input  logic              clk,
	input  clbc_pkg::cell_op_t op,
	input  logic              bit_in,
	input  clbc_pkg::digit_t  digit_in,
	output logic              carry_out,
	output clbc_pkg::digit_t  digit
);
	import clbc_pkg::*;

	digit_t d_q;
	digit_t adj;

	assign adj = (d_q >= 4'd5) ? d_q + 4'd3 : d_q;
	assign carry_out = adj[3];
	assign digit = d_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_CLEAR: d_q <= '0;
			CELL_CONV:  d_q <= {adj[2:0], bit_in};
			CELL_SHIFT: d_q <= digit_in;
			default:    d_q <= d_q;
		endcase
	end

endmodule

// ===== hw/rtl/clbc_scan.sv =====
// Digit scanner that accumulates the Luhn sum, digit count and leading digits.
module clbc_scan (
	input  logic                              clk,
	input  logic                              clear,
	input  logic                              en,
	input  logic [clbc_pkg::IdxWidth-1:0]     idx,
	input  clbc_pkg::digit_t                  digit,
	output clbc_pkg::scan_res_t               res
);
	import clbc_pkg::*;

	digit_t sum_q;
	digit_t prev_q;
	digit_t hi_q;
	digit_t lo_q;
	count_t count_q;
	logic [4:0] dbl;
	digit_t term;
	logic [4:0] acc;

	always_comb begin
		dbl = {digit, 1'b0};
		if (idx[0]) begin
			term = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
		end else begin
			term = digit;
		end
		acc = {1'b0, sum_q} + {1'b0, term};
		if (acc >= 5'd10) begin
			acc = acc - 5'd10;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			sum_q <= '0;
			prev_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			count_q <= '0;
		end else if (en) begin
			sum_q <= acc[3:0];
			prev_q <= digit;
			if (digit != 4'd0) begin
				hi_q <= digit;
				lo_q <= prev_q;
				count_q <= count_t'(idx) + 5'd1;
			end
		end
	end

	assign res.digit_count = count_q;
	assign res.luhn_ok = (sum_q == 4'd0);
	assign res.lead_hi = hi_q;
	assign res.lead_lo = lo_q;

endmodule

// ===== hw/rtl/card_number_luhn_brand_check.sv =====
// Top level of the card number checker: conversion chain, digit scan and control.
//
// A word goes from acceptance to a loaded result in these steps: the binary
// number shifts one bit per cycle through a chain of twenty decimal digit
// cells, the digits shift out of the chain into the Luhn and count scanner,
// and the brand is formed and loaded with the result once the output is free.
// The input side takes the next word as soon as the result is registered,
// while that result may still wait on the output.
module card_number_luhn_brand_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [clbc_pkg::CardWidth-1:0]    pan,
	output logic                              out_valid,
	input  logic                              out_ready,
	output clbc_pkg::brand_t                  brand,
	output logic                              luhn_ok,
	output clbc_pkg::count_t                  digit_count
);
	import clbc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [CntWidth-1:0] cnt_q;
	logic [CardWidth-1:0] bin_q;
	logic out_valid_q;
	brand_t brand_q;
	logic luhn_q;
	count_t count_q;

	cell_op_t cell_op;
	logic [NumCells-1:0] carry;
	digit_t digits [NumCells];
	scan_res_t res;
	brand_t brand_next;
	logic accept;
	logic out_free;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (state_q)
			ST_IDLE: cell_op = accept ? CELL_CLEAR : CELL_HOLD;
			ST_CONV: cell_op = CELL_CONV;
			ST_SCAN: cell_op = CELL_SHIFT;
			default: cell_op = CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		logic bit_in;
		digit_t digit_in;
		if (i == 0) begin : g_first
			assign bit_in = bin_q[CardWidth-1];
		end else begin : g_rest
			assign bit_in = carry[i-1];
		end
		if (i == NumCells - 1) begin : g_last
			assign digit_in = '0;
		end else begin : g_mid
			assign digit_in = digits[i+1];
		end
		clbc_cell u_cell (
			.clk       (clk),
			.op        (cell_op),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.carry_out (carry[i]),
			.digit     (digits[i])
		);
	end

	clbc_scan u_scan (
		.clk   (clk),
		.clear (accept),
		.en    (state_q == ST_SCAN),
		.idx   (cnt_q[IdxWidth-1:0]),
		.digit (digits[0]),
		.res   (res)
	);

	always_comb begin
		brand_next = BRAND_INVALID;
		if (res.luhn_ok && res.digit_count >= MIN_DIGITS
				&& res.digit_count <= MAX_DIGITS_C) begin
			if (res.lead_hi == 4'd3 && (res.lead_lo == 4'd4 || res.lead_lo == 4'd7)
					&& res.digit_count == AMEX_DIGITS) begin
				brand_next = BRAND_AMEX;
			end else if (res.lead_hi == 4'd4 && (res.digit_count == VISA_SHORT_DIGITS
					|| res.digit_count == CARD_DIGITS)) begin
				brand_next = BRAND_VISA;
			end else if (res.lead_hi == 4'd5 && res.lead_lo >= 4'd1
					&& res.lead_lo <= 4'd5 && res.digit_count == CARD_DIGITS) begin
				brand_next = BRAND_MASTER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == CntWidth'(CardWidth - 1)) begin
						cnt_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == CntWidth'(NumCells - 1)) begin
						cnt_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= pan;
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[CardWidth-2:0], 1'b0};
		end
		if (state_q == ST_DONE && out_free) begin
			brand_q <= brand_next;
			luhn_q <= res.luhn_ok;
			count_q <= res.digit_count;
		end
	end

	assign out_valid = out_valid_q;
	assign brand = brand_q;
	assign luhn_ok = luhn_q;
	assign digit_count = count_q;

endmodule
